// ===== sv/pfc_pkg.sv =====
// ----------------------------------------------------------------------------
// pfc_pkg
// Types, constants and helpers shared by the Playfair digraph cipher.
// ----------------------------------------------------------------------------
package pfc_pkg;

  localparam int unsigned Dim   = 5;
  localparam int unsigned CodeW = 5;
  localparam int unsigned IdxW  = 3;
  localparam int unsigned CfgW  = 50;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CfgRows01 = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRows23 = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRow4   = 2'd2;

  typedef logic [CodeW-1:0] code_t;
  typedef logic [IdxW-1:0]  idx_t;

  // indexed [row][col]
  typedef code_t [Dim-1:0][Dim-1:0] square_t;

  typedef struct packed {
    logic found;
    idx_t row;
    idx_t col;
  } pos_t;

  // one step around the square, forward on encrypt, back on decrypt
  function automatic idx_t wrap_step(idx_t x, logic dec);
    idx_t y;
    if (dec) begin
      y = (x == '0) ? IdxW'(Dim - 1) : x - IdxW'(1);
    end else begin
      y = (x == IdxW'(Dim - 1)) ? '0 : x + IdxW'(1);
    end
    return y;
  endfunction

endpackage

// ===== sv/pfc_lane.sv =====
// ----------------------------------------------------------------------------
// pfc_lane
// Search lane: compares one letter against all square cells in parallel and
// reports the row and column of the last matching cell in row-major order.
// ----------------------------------------------------------------------------
module pfc_lane (
  input  pfc_pkg::square_t square,
  input  pfc_pkg::code_t   letter,
  output pfc_pkg::pos_t    pos
);
  import pfc_pkg::*;

  always_comb begin
    pos = '0;
    for (int r = 0; r < Dim; r++) begin
      for (int c = 0; c < Dim; c++) begin
        if (square[r][c] == letter) begin
          pos.found = 1'b1;
          pos.row   = IdxW'(r);
          pos.col   = IdxW'(c);
        end
      end
    end
  end

endmodule

// ===== sv/pfc_merge.sv =====
// ----------------------------------------------------------------------------
// pfc_merge
// Merge stage: applies the column, row or rectangle rule to the two lane
// results and reads the new letters from the square, or passes misses through.
// ----------------------------------------------------------------------------
module pfc_merge (
  input  logic             cmd,
  input  pfc_pkg::square_t square,
  input  pfc_pkg::code_t   first_letter,
  input  pfc_pkg::code_t   second_letter,
  input  pfc_pkg::pos_t    pos_a,
  input  pfc_pkg::pos_t    pos_b,
  output pfc_pkg::code_t   first_out,
  output pfc_pkg::code_t   second_out,
  output logic             not_in_square
);
  import pfc_pkg::*;

  idx_t ra_n;
  idx_t ca_n;
  idx_t rb_n;
  idx_t cb_n;

  always_comb begin
    ra_n = pos_a.row;
    ca_n = pos_a.col;
    rb_n = pos_b.row;
    cb_n = pos_b.col;
    if (pos_a.col == pos_b.col) begin
      ra_n = wrap_step(pos_a.row, cmd);
      rb_n = wrap_step(pos_b.row, cmd);
    end else if (pos_a.row == pos_b.row) begin
      ca_n = wrap_step(pos_a.col, cmd);
      cb_n = wrap_step(pos_b.col, cmd);
    end else begin
      ca_n = pos_b.col;
      cb_n = pos_a.col;
    end
  end

  assign not_in_square = !(pos_a.found && pos_b.found);
  assign first_out     = not_in_square ? first_letter  : square[ra_n][ca_n];
  assign second_out    = not_in_square ? second_letter : square[rb_n][cb_n];

endmodule

// ===== sv/playfair_digraph_cipher_top.sv =====
// ----------------------------------------------------------------------------
// playfair_digraph_cipher_top
// Playfair digraph cipher over a keyed 5x5 square held in configuration.
// ----------------------------------------------------------------------------
// One digraph word enters per cycle while the output is not stalled. In the
// accepting cycle two search lanes locate both letters against all 25 cells
// at once and the positions are registered in the search stage; the merge
// stage then applies the rule and the substituted letters are read into the
// output register. Sustained rate is one word per cycle without backpressure;
// the two-stage pipeline holds on backpressure and no reset sweep is needed.
module playfair_digraph_cipher_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [49:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // first_letter[4:0], second_letter[9:5]
  input  logic [0:0]  s_axis_tuser,   // cmd[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // first_out[4:0], second_out[9:5]
  output logic [0:0]  m_axis_tuser    // not_in_square[0]
);
  import pfc_pkg::*;

  logic [49:0] sq01;
  logic [49:0] sq23;
  logic [24:0] sq4;
  square_t     square;

  logic        s1_valid;
  logic        s1_cmd;
  code_t       s1_first;
  code_t       s1_second;
  pos_t        s1_pos_a;
  pos_t        s1_pos_b;

  pos_t        pos_a_next;
  pos_t        pos_b_next;
  code_t       first_next;
  code_t       second_next;
  logic        miss_next;
  logic        s2_adv;
  logic        s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq01 <= '0;
      sq23 <= '0;
      sq4  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgRows01: sq01 <= cfg_data;
        CfgRows23: sq23 <= cfg_data;
        CfgRow4:   sq4  <= cfg_data[24:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int r = 0; r < Dim; r++) begin
      for (int c = 0; c < Dim; c++) begin
        if (r < 2) begin
          square[r][c] = sq01[CodeW*(r*Dim+c) +: CodeW];
        end else if (r < 4) begin
          square[r][c] = sq23[CodeW*((r-2)*Dim+c) +: CodeW];
        end else begin
          square[r][c] = sq4[CodeW*c +: CodeW];
        end
      end
    end
  end

  pfc_lane u_lane_a (
    .square (square),
    .letter (s_axis_tdata[4:0]),
    .pos    (pos_a_next)
  );

  pfc_lane u_lane_b (
    .square (square),
    .letter (s_axis_tdata[9:5]),
    .pos    (pos_b_next)
  );

  pfc_merge u_merge (
    .cmd           (s1_cmd),
    .square        (square),
    .first_letter  (s1_first),
    .second_letter (s1_second),
    .pos_a         (s1_pos_a),
    .pos_b         (s1_pos_b),
    .first_out     (first_next),
    .second_out    (second_next),
    .not_in_square (miss_next)
  );

  assign s2_adv        = !m_axis_tvalid || m_axis_tready;
  assign s1_adv        = !s1_valid || s2_adv;
  assign s_axis_tready = s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= s_axis_tvalid;
    end
    if (s1_adv && s_axis_tvalid) begin
      s1_cmd    <= s_axis_tuser[0];
      s1_first  <= s_axis_tdata[4:0];
      s1_second <= s_axis_tdata[9:5];
      s1_pos_a  <= pos_a_next;
      s1_pos_b  <= pos_b_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s2_adv) begin
      m_axis_tvalid <= s1_valid;
    end
    if (s2_adv && s1_valid) begin
      m_axis_tdata <= {6'b0, second_next, first_next};
      m_axis_tuser <= miss_next;
    end
  end

  a_accept_fills_s1 : assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> s1_valid)
    else $error("accepted word did not reach search stage");

  a_s1_holds : assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_adv |=> s1_valid && $stable(s1_first) && $stable(s1_pos_a))
    else $error("search stage changed while stalled");

  a_miss_passes : assert property (@(posedge clk) disable iff (rst)
    s1_valid && s2_adv && !(s1_pos_a.found && s1_pos_b.found) |=>
    m_axis_tuser[0] && m_axis_tdata[4:0] == $past(s1_first)
    && m_axis_tdata[9:5] == $past(s1_second))
    else $error("absent letter not passed through");

  a_ready_rule : assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!s1_valid || !m_axis_tvalid || m_axis_tready))
    else $error("input ready inconsistent with pipeline occupancy");

endmodule
